@@ hdl/bohl_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bohl_pkg
// Shared types and defaults for the bounded ordered handle list: request
// and status codes, sequencer states, and the structs between the modules.
// ----------------------------------------------------------------------------
package bohl_pkg;

    localparam int LIST_MAX_DEF    = 64;
    localparam int HANDLE_BITS_DEF = 6;

    localparam int REQ_BITS    = 3;
    localparam int STATUS_BITS = 3;

    typedef enum logic [REQ_BITS-1:0] {
        REQ_APPEND = 3'd0,
        REQ_REMOVE = 3'd1,
        REQ_MEMBER = 3'd2,
        REQ_READ   = 3'd3,
        REQ_FIRST  = 3'd4,
        REQ_NEXT   = 3'd5,
        REQ_CLEAR  = 3'd6
    } req_e_t;

    typedef enum logic [STATUS_BITS-1:0] {
        ST_OK        = 3'd0,
        ST_FULL      = 3'd1,
        ST_NOT_FOUND = 3'd2,
        ST_RANGE     = 3'd3,
        ST_END       = 3'd4
    } status_e_t;

    typedef enum logic [2:0] {
        S_IDLE  = 3'd0,
        S_SCAN  = 3'd1,
        S_SHIFT = 3'd2,
        S_READ  = 3'd3,
        S_RESP  = 3'd4
    } state_e_t;

    // Port strobes from the sequencer to the entry memory
    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } mem_ctl_t;

    // Result flags from the sequencer to the output register
    typedef struct packed {
        logic      hit;
        status_e_t status;
    } res_flags_t;

endpackage

@@ hdl/bohl_mem.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bohl_mem
// Entry store: one write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module bohl_mem #(
    parameter int DEPTH = bohl_pkg::LIST_MAX_DEF,
    parameter int WIDTH = bohl_pkg::HANDLE_BITS_DEF,
    localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                     clk,
    input  bohl_pkg::mem_ctl_t       ctl,
    input  logic [ADDR_BITS-1:0]     wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [ADDR_BITS-1:0]     rd_addr,
    output logic [WIDTH-1:0]         rd_data
);
    import bohl_pkg::*;

    logic [WIDTH-1:0] entries_mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            entries_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.rd_en)
        begin
            rd_data_reg <= entries_mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ hdl/bohl_seq.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bohl_seq
// Request sequencer: holds count and cursor, drives the entry memory for
// append, scan, close-up and reads, and builds one result per request.
// ----------------------------------------------------------------------------
module bohl_seq #(
    parameter int LIST_MAX    = bohl_pkg::LIST_MAX_DEF,
    parameter int HANDLE_BITS = bohl_pkg::HANDLE_BITS_DEF,
    localparam int ADDR_BITS  = (LIST_MAX > 1) ? $clog2(LIST_MAX) : 1,
    localparam int CNT_BITS   = $clog2(LIST_MAX + 1)
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        req_valid,
    output logic                        req_stall,
    input  logic [bohl_pkg::REQ_BITS-1:0] req_type,
    input  logic [HANDLE_BITS-1:0]      handle,
    input  logic [ADDR_BITS-1:0]        position,
    output logic                        res_valid,
    input  logic                        res_take,
    output logic [HANDLE_BITS-1:0]      res_item,
    output bohl_pkg::res_flags_t        res_flags,
    output logic [CNT_BITS-1:0]         res_count,
    output bohl_pkg::mem_ctl_t          mem_ctl,
    output logic [ADDR_BITS-1:0]        mem_wr_addr,
    output logic [HANDLE_BITS-1:0]      mem_wr_data,
    output logic [ADDR_BITS-1:0]        mem_rd_addr,
    input  logic [HANDLE_BITS-1:0]      mem_rd_data
);
    import bohl_pkg::*;

    localparam logic [CNT_BITS-1:0] CNT_MAX = CNT_BITS'(LIST_MAX);
    localparam logic [CNT_BITS-1:0] CNT_ONE = CNT_BITS'(1);

    state_e_t               state_reg,   state_next;
    req_e_t                 op_reg,      op_next;
    logic [HANDLE_BITS-1:0] key_reg,     key_next;
    logic [CNT_BITS-1:0]    count_reg,   count_next;
    logic [CNT_BITS-1:0]    cursor_reg,  cursor_next;
    logic [CNT_BITS-1:0]    idx_reg,     idx_next;
    logic [CNT_BITS-1:0]    cmp_idx_reg, cmp_idx_next;
    logic [CNT_BITS-1:0]    wr_idx_reg,  wr_idx_next;
    logic [HANDLE_BITS-1:0] item_reg,    item_next;
    logic                   hit_reg,     hit_next;
    status_e_t              status_reg,  status_next;

    logic   accept;
    req_e_t req_op;
    logic   list_full;
    logic   list_empty;
    logic   pos_ok;
    logic   cur_ok;
    logic   match;
    logic   last_cmp;
    logic   more_rd;

    assign accept     = req_valid && (state_reg == S_IDLE);
    assign req_op     = req_e_t'(req_type);
    assign list_full  = (count_reg == CNT_MAX);
    assign list_empty = (count_reg == '0);
    assign pos_ok     = (CNT_BITS'(position) < count_reg);
    assign cur_ok     = (cursor_reg < count_reg);
    assign match      = (mem_rd_data == key_reg);
    assign last_cmp   = ((cmp_idx_reg + CNT_ONE) == count_reg);
    assign more_rd    = (idx_reg < count_reg);

    assign req_stall = (state_reg != S_IDLE);
    assign res_valid = (state_reg == S_RESP);
    assign res_item  = item_reg;
    assign res_flags = '{hit: hit_reg, status: status_reg};
    assign res_count = count_reg;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (req_op)
                        REQ_REMOVE, REQ_MEMBER: state_next = list_empty ? S_RESP : S_SCAN;
                        REQ_READ:               state_next = pos_ok ? S_READ : S_RESP;
                        REQ_FIRST:              state_next = list_empty ? S_RESP : S_READ;
                        REQ_NEXT:               state_next = cur_ok ? S_READ : S_RESP;
                        default:                state_next = S_RESP;
                    endcase
                end
            end
            S_SCAN:
            begin
                if (match)
                begin
                    state_next = (op_reg == REQ_MEMBER || last_cmp) ? S_RESP : S_SHIFT;
                end
                else if (last_cmp)
                begin
                    state_next = S_RESP;
                end
            end
            S_SHIFT:
            begin
                if (!more_rd)
                begin
                    state_next = S_RESP;
                end
            end
            S_READ:
            begin
                state_next = S_RESP;
            end
            S_RESP:
            begin
                if (res_take)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Datapath and memory strobes
    always_comb
    begin
        op_next      = op_reg;
        key_next     = key_reg;
        count_next   = count_reg;
        cursor_next  = cursor_reg;
        idx_next     = idx_reg;
        cmp_idx_next = cmp_idx_reg;
        wr_idx_next  = wr_idx_reg;
        item_next    = item_reg;
        hit_next     = hit_reg;
        status_next  = status_reg;
        mem_ctl      = '{rd_en: 1'b0, wr_en: 1'b0};
        mem_wr_addr  = wr_idx_reg[ADDR_BITS-1:0];
        mem_wr_data  = mem_rd_data;
        mem_rd_addr  = idx_reg[ADDR_BITS-1:0];

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    op_next      = req_op;
                    key_next     = handle;
                    item_next    = '0;
                    hit_next     = 1'b0;
                    status_next  = ST_OK;
                    idx_next     = CNT_ONE;
                    cmp_idx_next = '0;
                    case (req_op)
                        REQ_APPEND:
                        begin
                            if (list_full)
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                mem_ctl.wr_en = 1'b1;
                                mem_wr_addr   = count_reg[ADDR_BITS-1:0];
                                mem_wr_data   = handle;
                                count_next    = count_reg + CNT_ONE;
                            end
                        end
                        REQ_REMOVE, REQ_MEMBER:
                        begin
                            if (list_empty)
                            begin
                                status_next = ST_NOT_FOUND;
                            end
                            else
                            begin
                                mem_ctl.rd_en = 1'b1;
                                mem_rd_addr   = '0;
                            end
                        end
                        REQ_READ:
                        begin
                            if (pos_ok)
                            begin
                                mem_ctl.rd_en = 1'b1;
                                mem_rd_addr   = position;
                            end
                            else
                            begin
                                status_next = ST_RANGE;
                            end
                        end
                        REQ_FIRST:
                        begin
                            if (list_empty)
                            begin
                                status_next = ST_END;
                            end
                            else
                            begin
                                mem_ctl.rd_en = 1'b1;
                                mem_rd_addr   = '0;
                                cursor_next   = CNT_ONE;
                            end
                        end
                        REQ_NEXT:
                        begin
                            if (cur_ok)
                            begin
                                mem_ctl.rd_en = 1'b1;
                                mem_rd_addr   = cursor_reg[ADDR_BITS-1:0];
                                cursor_next   = cursor_reg + CNT_ONE;
                            end
                            else
                            begin
                                status_next = ST_END;
                            end
                        end
                        REQ_CLEAR:
                        begin
                            count_next  = '0;
                            cursor_next = '0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                // Read one entry ahead while comparing the one just returned
                cmp_idx_next = idx_reg;
                if (more_rd)
                begin
                    mem_ctl.rd_en = 1'b1;
                    idx_next      = idx_reg + CNT_ONE;
                end
                if (match)
                begin
                    hit_next = 1'b1;
                    if (op_reg == REQ_REMOVE)
                    begin
                        wr_idx_next = cmp_idx_reg;
                        if (cmp_idx_reg < cursor_reg)
                        begin
                            cursor_next = cursor_reg - CNT_ONE;
                        end
                        if (last_cmp)
                        begin
                            count_next = count_reg - CNT_ONE;
                        end
                    end
                end
                else if (last_cmp)
                begin
                    status_next = ST_NOT_FOUND;
                end
            end
            S_SHIFT:
            begin
                // Close up: the entry read last cycle moves down one place
                mem_ctl.wr_en = 1'b1;
                wr_idx_next   = wr_idx_reg + CNT_ONE;
                if (more_rd)
                begin
                    mem_ctl.rd_en = 1'b1;
                    idx_next      = idx_reg + CNT_ONE;
                end
                else
                begin
                    count_next = count_reg - CNT_ONE;
                end
            end
            S_READ:
            begin
                item_next = mem_rd_data;
                hit_next  = 1'b1;
            end
            S_RESP:
            begin
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            cursor_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            cursor_reg <= cursor_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        key_reg     <= key_next;
        idx_reg     <= idx_next;
        cmp_idx_reg <= cmp_idx_next;
        wr_idx_reg  <= wr_idx_next;
        item_reg    <= item_next;
        hit_reg     <= hit_next;
        status_reg  <= status_next;
    end

endmodule

@@ hdl/bounded_ordered_handle_list.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_ordered_handle_list
// Insertion-ordered list of handles with an iteration cursor, kept in one
// synchronous entry memory, with a registered result channel.
// ----------------------------------------------------------------------------
// The block takes one request at a time. Append, clear, unknown codes and
// requests rejected on count alone go straight to the result; read, first
// and next first read one entry. Member test and remove scan the list
// through the single memory read port, one entry per cycle, and a remove
// then closes up the later entries one per cycle. The result sits in an
// output register, so the next request is taken while a result still
// waits on rsp_stall. Entries need no clearing after reset.
module bounded_ordered_handle_list #(
    parameter int LIST_MAX    = bohl_pkg::LIST_MAX_DEF,
    parameter int HANDLE_BITS = bohl_pkg::HANDLE_BITS_DEF,
    localparam int ADDR_BITS  = (LIST_MAX > 1) ? $clog2(LIST_MAX) : 1,
    localparam int CNT_BITS   = $clog2(LIST_MAX + 1)
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           req_valid,
    output logic                           req_stall,
    input  logic [bohl_pkg::REQ_BITS-1:0]  req_type,
    input  logic [HANDLE_BITS-1:0]         handle,
    input  logic [ADDR_BITS-1:0]           position,
    output logic                           rsp_valid,
    input  logic                           rsp_stall,
    output logic [HANDLE_BITS-1:0]         item,
    output logic                           hit,
    output logic [CNT_BITS-1:0]            count,
    output logic                           is_empty,
    output logic                           is_full,
    output logic [bohl_pkg::STATUS_BITS-1:0] status
);
    import bohl_pkg::*;

    localparam logic [CNT_BITS-1:0] CNT_MAX = CNT_BITS'(LIST_MAX);

    mem_ctl_t               mem_ctl;
    logic [ADDR_BITS-1:0]   mem_wr_addr;
    logic [HANDLE_BITS-1:0] mem_wr_data;
    logic [ADDR_BITS-1:0]   mem_rd_addr;
    logic [HANDLE_BITS-1:0] mem_rd_data;

    logic                   res_valid;
    logic                   res_take;
    logic [HANDLE_BITS-1:0] res_item;
    res_flags_t             res_flags;
    logic [CNT_BITS-1:0]    res_count;

    logic                   rsp_valid_reg, rsp_valid_next;
    logic [HANDLE_BITS-1:0] item_reg;
    logic                   hit_reg;
    logic [CNT_BITS-1:0]    count_reg;
    logic                   is_empty_reg;
    logic                   is_full_reg;
    status_e_t              status_reg;

    bohl_seq #(
        .LIST_MAX    (LIST_MAX),
        .HANDLE_BITS (HANDLE_BITS)
    ) u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .req_type    (req_type),
        .handle      (handle),
        .position    (position),
        .res_valid   (res_valid),
        .res_take    (res_take),
        .res_item    (res_item),
        .res_flags   (res_flags),
        .res_count   (res_count),
        .mem_ctl     (mem_ctl),
        .mem_wr_addr (mem_wr_addr),
        .mem_wr_data (mem_wr_data),
        .mem_rd_addr (mem_rd_addr),
        .mem_rd_data (mem_rd_data)
    );

    bohl_mem #(
        .DEPTH (LIST_MAX),
        .WIDTH (HANDLE_BITS)
    ) u_mem (
        .clk     (clk),
        .ctl     (mem_ctl),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    // Load the output register when it is empty or its result is leaving
    assign res_take = res_valid && (!rsp_valid_reg || !rsp_stall);

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (res_take)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_take)
        begin
            item_reg     <= res_item;
            hit_reg      <= res_flags.hit;
            status_reg   <= res_flags.status;
            count_reg    <= res_count;
            is_empty_reg <= (res_count == '0);
            is_full_reg  <= (res_count == CNT_MAX);
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign item      = item_reg;
    assign hit       = hit_reg;
    assign count     = count_reg;
    assign is_empty  = is_empty_reg;
    assign is_full   = is_full_reg;
    assign status    = status_reg;

endmodule

@@ hdl/bohl_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bohl_checker
// Port-level checks on the handle list, bound to the top level.
// ----------------------------------------------------------------------------
module bohl_checker #(
    parameter int LIST_MAX    = bohl_pkg::LIST_MAX_DEF,
    parameter int HANDLE_BITS = bohl_pkg::HANDLE_BITS_DEF,
    localparam int CNT_BITS   = $clog2(LIST_MAX + 1)
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             req_valid,
    input  logic                             req_stall,
    input  logic                             rsp_valid,
    input  logic                             rsp_stall,
    input  logic [HANDLE_BITS-1:0]           item,
    input  logic                             hit,
    input  logic [CNT_BITS-1:0]              count,
    input  logic                             is_empty,
    input  logic                             is_full,
    input  logic [bohl_pkg::STATUS_BITS-1:0] status
);
    import bohl_pkg::*;

    // A request in flight blocks the next one
    assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall) |=> req_stall)
    else $error("request taken while previous request still in progress");

    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (is_empty == (count == '0)))
    else $error("is_empty disagrees with count");

    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> !(is_empty && is_full))
    else $error("list reported both empty and full");

    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !hit) |-> (item == '0))
    else $error("item nonzero without hit");

    // Hold a stalled result
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(item) && $stable(status)))
    else $error("stalled result changed");

endmodule

bind bounded_ordered_handle_list bohl_checker #(
    .LIST_MAX    (LIST_MAX),
    .HANDLE_BITS (HANDLE_BITS)
) u_bohl_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .item      (item),
    .hit       (hit),
    .count     (count),
    .is_empty  (is_empty),
    .is_full   (is_full),
    .status    (status)
);
